@@ hw/rtl/jswt_pkg.sv @@
// ----------------------------------------------------------------------------
// jswt_pkg: shared types and helpers for the weighted-tardiness job sorter
// Job record, cell control bundle, saturation limits and the sort order test.
// ----------------------------------------------------------------------------
package jswt_pkg;

	localparam int unsigned ID_W   = 16;
	localparam int unsigned DUR_W  = 16;
	localparam int unsigned DL_W   = 24;
	localparam int unsigned PRI_W  = 8;
	localparam int unsigned TIME_W = 24;
	localparam int unsigned PEN_W  = 40;
	localparam int unsigned PROD_W = TIME_W + PRI_W;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [PEN_W-1:0]  PEN_MAX  = '1;

	// sort_mode register codes
	localparam logic MODE_EDF = 1'b0;
	localparam logic MODE_HPF = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [DUR_W-1:0] dur;
		logic [DL_W-1:0]  dl;
		logic [PRI_W-1:0] pri;
	} job_t;

	// Control broadcast from the top level to every cell
	typedef struct packed {
		logic ins;   // insert new_job this cycle
		logic pop;   // shift the whole row one place toward the head
		logic mode;  // sort order
	} cell_ctrl_t;

	// True when job a must be placed strictly after job b
	function automatic logic goes_after(input job_t a, input job_t b, input logic mode);
		logic res;
		if (mode == MODE_HPF) begin
			res = (a.pri < b.pri);
		end else begin
			res = (a.dl > b.dl);
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/jswt_cell.sv @@
// ----------------------------------------------------------------------------
// jswt_cell: one slot of the systolic insertion sorter
// Holds one job. On insert, a cell whose job goes after the new one (or that
// is empty) is displaced: it takes its left neighbor's job if that one was
// displaced too, else the new job. On pop every cell takes its right
// neighbor's job, so the row drains through cell 0 in sorted order.
// ----------------------------------------------------------------------------
module jswt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jswt_pkg::cell_ctrl_t  ctrl,
	input  jswt_pkg::job_t        new_job,
	input  jswt_pkg::job_t        prev_job,
	input  logic                  prev_valid,
	input  logic                  prev_disp,
	input  jswt_pkg::job_t        next_job,
	input  logic                  next_valid,
	output jswt_pkg::job_t        job,
	output logic                  valid,
	output logic                  disp
);

	jswt_pkg::job_t job_q;
	logic           valid_q;

	// displaced when empty or strictly later than the new job (keeps ties stable)
	assign disp  = ctrl.ins & (~valid_q | jswt_pkg::goes_after(job_q, new_job, ctrl.mode));
	assign job   = job_q;
	assign valid = valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.pop) begin
			valid_q <= next_valid;
		end else if (disp) begin
			valid_q <= prev_disp ? prev_valid : 1'b1;
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			job_q <= next_job;
		end else if (disp) begin
			job_q <= prev_disp ? prev_job : new_job;
		end
	end

endmodule

@@ hw/rtl/job_sort_weighted_tardiness.sv @@
// Load: one job per cycle into a row of MAX_JOBS sorter cells (in_ready high).
// Emit: starts the cycle after the last job beat; each result steps through the
//   time add, multiply and accumulate states into the output register, and
//   waits in the accumulate state while the output is stalled.
// Reset: all cells empty, counters, elapsed time, penalty and sort_mode cleared.
// ----------------------------------------------------------------------------
// job_sort_weighted_tardiness: EDF / HPF job sorter with weighted tardiness
// Loads a job set into a systolic insertion sorter, then drains it in order,
// accumulating finish time and saturating weighted tardiness per result.
// ----------------------------------------------------------------------------
module job_sort_weighted_tardiness #(
	parameter int unsigned MAX_JOBS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// job input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] job_id,
	input  logic [15:0] job_duration,
	input  logic [23:0] job_deadline,
	input  logic [7:0]  job_priority,
	input  logic        last_job,
	// schedule output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_job_id,
	output logic [15:0] out_duration,
	output logic [23:0] out_deadline,
	output logic [7:0]  out_priority,
	output logic [23:0] finish_time,
	output logic [39:0] penalty_sum,
	output logic        last_result
);

	localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_TIME = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_ACC  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic                         sort_mode_q;
	logic [CNT_W-1:0]             job_count_q;
	logic [CNT_W-1:0]             emit_left_q;
	logic [jswt_pkg::TIME_W-1:0]  elapsed_q;
	logic [jswt_pkg::PEN_W-1:0]   pen_q;
	jswt_pkg::job_t               cur_s1;
	logic [jswt_pkg::PROD_W-1:0]  prod_s2;

	jswt_pkg::job_t               out_job_q;
	logic [jswt_pkg::TIME_W-1:0]  out_fin_q;
	logic [jswt_pkg::PEN_W-1:0]   out_pen_q;
	logic                         out_last_q;
	logic                         out_valid_q;

	jswt_pkg::cell_ctrl_t         ctrl;
	jswt_pkg::job_t               new_job;
	jswt_pkg::job_t               cell_job   [MAX_JOBS];
	logic                         cell_valid [MAX_JOBS];
	logic                         cell_disp  [MAX_JOBS];

	logic                         in_acc;
	logic                         has_room;
	logic                         out_free;
	logic [jswt_pkg::TIME_W:0]    time_sum;
	logic                         late;
	logic [jswt_pkg::TIME_W-1:0]  tardy;
	logic [jswt_pkg::PEN_W:0]     pen_sum;
	logic [jswt_pkg::PEN_W-1:0]   pen_next;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_LOAD);
	assign in_acc    = in_valid & in_ready;
	assign has_room  = (job_count_q < CNT_W'(MAX_JOBS));
	assign out_free  = ~out_valid_q | out_ready;

	assign new_job.id  = job_id;
	assign new_job.dur = job_duration;
	assign new_job.dl  = job_deadline;
	assign new_job.pri = job_priority;

	assign ctrl.ins  = in_acc & has_room;
	assign ctrl.pop  = (state_q == ST_TIME);
	assign ctrl.mode = sort_mode_q;

	// sorter row
	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		jswt_pkg::job_t prev_job_w;
		jswt_pkg::job_t next_job_w;
		logic           prev_valid_w;
		logic           prev_disp_w;
		logic           next_valid_w;

		if (i == 0) begin : g_head
			assign prev_job_w   = '0;
			assign prev_valid_w = 1'b0;
			assign prev_disp_w  = 1'b0;
		end else begin : g_mid
			assign prev_job_w   = cell_job[i-1];
			assign prev_valid_w = cell_valid[i-1];
			assign prev_disp_w  = cell_disp[i-1];
		end

		if (i == MAX_JOBS - 1) begin : g_tail
			assign next_job_w   = '0;
			assign next_valid_w = 1'b0;
		end else begin : g_body
			assign next_job_w   = cell_job[i+1];
			assign next_valid_w = cell_valid[i+1];
		end

		jswt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_job    (new_job),
			.prev_job   (prev_job_w),
			.prev_valid (prev_valid_w),
			.prev_disp  (prev_disp_w),
			.next_job   (next_job_w),
			.next_valid (next_valid_w),
			.job        (cell_job[i]),
			.valid      (cell_valid[i]),
			.disp       (cell_disp[i])
		);
	end

	// emit datapath arithmetic
	assign time_sum = {1'b0, elapsed_q} + {{(jswt_pkg::TIME_W - jswt_pkg::DUR_W + 1){1'b0}},
		cell_job[0].dur};
	assign late     = (elapsed_q > cur_s1.dl);
	assign tardy    = elapsed_q - cur_s1.dl;
	assign pen_sum  = {1'b0, pen_q} + {{(jswt_pkg::PEN_W - jswt_pkg::PROD_W + 1){1'b0}}, prod_s2};
	assign pen_next = pen_sum[jswt_pkg::PEN_W] ? jswt_pkg::PEN_MAX
		: pen_sum[jswt_pkg::PEN_W-1:0];

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= jswt_pkg::MODE_EDF;
		end else if (cfg_valid && cfg_ready) begin
			sort_mode_q <= cfg_data;
		end
	end

	// control: load, then time / multiply / accumulate per job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			job_count_q <= '0;
			emit_left_q <= '0;
			elapsed_q   <= '0;
			pen_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drained beat; a new result in the accumulate state refills it
			if (out_valid_q && out_ready && (state_q != ST_ACC)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (last_job) begin
							emit_left_q <= job_count_q + CNT_W'(has_room);
							job_count_q <= '0;
							state_q     <= ST_TIME;
						end else if (has_room) begin
							job_count_q <= job_count_q + CNT_W'(1);
						end
					end
				end
				ST_TIME: begin
					elapsed_q <= time_sum[jswt_pkg::TIME_W] ? jswt_pkg::TIME_MAX
						: time_sum[jswt_pkg::TIME_W-1:0];
					state_q   <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						emit_left_q <= emit_left_q - CNT_W'(1);
						if (emit_left_q == CNT_W'(1)) begin
							elapsed_q <= '0;
							pen_q     <= '0;
							state_q   <= ST_LOAD;
						end else begin
							pen_q   <= pen_next;
							state_q <= ST_TIME;
						end
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// emit pipeline payload
	always_ff @(posedge clk) begin
		if (state_q == ST_TIME) begin
			cur_s1 <= cell_job[0];
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= late ? (jswt_pkg::PROD_W'(tardy) * jswt_pkg::PROD_W'(cur_s1.pri)) : '0;
		end
		if (state_q == ST_ACC && out_free) begin
			out_job_q  <= cur_s1;
			out_fin_q  <= elapsed_q;
			out_pen_q  <= pen_next;
			out_last_q <= (emit_left_q == CNT_W'(1));
		end
	end

	assign out_valid    = out_valid_q;
	assign out_job_id   = out_job_q.id;
	assign out_duration = out_job_q.dur;
	assign out_deadline = out_job_q.dl;
	assign out_priority = out_job_q.pri;
	assign finish_time  = out_fin_q;
	assign penalty_sum  = out_pen_q;
	assign last_result  = out_last_q;

endmodule
